@@ rtl/core/vrc_pkg.sv @@
package vrc_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_KERNEL     = 5;
	localparam int CHANNELS       = 3;
	localparam int PIXEL_BITS     = 8;
	localparam int COEF_FRAC_BITS = 12;

	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int NUM_COEF   = MAX_KERNEL * MAX_KERNEL;
	localparam int KSEL_BITS  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int COEF_BITS  = 16;
	localparam int PROD_BITS  = COEF_BITS + PIXEL_BITS + 1;
	localparam int ACC_BITS   = PROD_BITS + $clog2(NUM_COEF);
	localparam int CFG_W_BITS = 11;

	// configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_KERNEL_ROWS  = 3'd2;
	localparam logic [2:0] REG_KERNEL_COLS  = 3'd3;
	localparam logic [2:0] REG_ANCHOR_ROW   = 3'd4;
	localparam logic [2:0] REG_ANCHOR_COL   = 3'd5;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_COEF  = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef pix_t [CHANNELS-1:0] rgb_t;
	typedef rgb_t [MAX_KERNEL-2:0] hist_t;
	typedef rgb_t [MAX_KERNEL-1:0] kcol_t;
	typedef kcol_t [MAX_KERNEL-1:0] window_t;
	typedef pix_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] plane_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef coef_t [NUM_COEF-1:0] coef_arr_t;

	typedef struct packed {
		logic                command;
		logic [7:0]          pixel_ch0;
		logic [7:0]          pixel_ch1;
		logic [7:0]          pixel_ch2;
		logic [4:0]          coef_index;
		logic signed [15:0]  coef_value;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_ch0;
		logic [7:0]  out_ch1;
		logic [7:0]  out_ch2;
		logic [15:0] out_row;
		logic [9:0]  out_col;
		logic        frame_last;
	} out_word_t;

	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic [COL_BITS-1:0] rd_addr;
		logic [COL_BITS-1:0] wr_addr;
	} win_ctl_t;

endpackage

@@ rtl/core/vrc_window.sv @@
module vrc_window (
	input  logic               clk,
	input  vrc_pkg::win_ctl_t  ctl,
	input  vrc_pkg::rgb_t      px,
	output vrc_pkg::window_t   window
);
	import vrc_pkg::*;

	hist_t   mem [MAX_WIDTH];
	hist_t   rd_q;
	hist_t   wr_data;
	kcol_t   colv;
	window_t win_q;

	// column entering the window: stored history plus the new pixel at the bottom
	always_comb begin
		for (int k = 0; k < MAX_KERNEL - 1; k++) begin
			colv[k] = rd_q[k];
		end
		colv[MAX_KERNEL-1] = px;
		for (int k = 0; k < MAX_KERNEL - 1; k++) begin
			wr_data[k] = colv[k+1];
		end
	end

	// forward the word being written when the same column is read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= (ctl.wr_en && ctl.wr_addr == ctl.rd_addr) ? wr_data : mem[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			for (int m = 0; m < MAX_KERNEL - 1; m++) begin
				win_q[m] <= win_q[m+1];
			end
			win_q[MAX_KERNEL-1] <= colv;
		end
	end

	assign window = win_q;

endmodule

@@ rtl/core/vrc_lane.sv @@
module vrc_lane (
	input  logic               clk,
	input  logic               en,
	input  vrc_pkg::plane_t    plane,
	input  vrc_pkg::coef_arr_t coefs,
	input  logic [2:0]         kr,
	input  logic [2:0]         kc,
	output vrc_pkg::pix_t      result
);
	import vrc_pkg::*;

	localparam int Q_BITS = ACC_BITS - COEF_FRAC_BITS;

	logic signed [PROD_BITS-1:0] prod_c  [MAX_KERNEL][MAX_KERNEL];
	logic signed [PROD_BITS-1:0] prod_s3 [MAX_KERNEL][MAX_KERNEL];
	logic signed [ACC_BITS-1:0]  row_c   [MAX_KERNEL];
	logic signed [ACC_BITS-1:0]  row_s4  [MAX_KERNEL];
	logic [KSEL_BITS-1:0]        ri [MAX_KERNEL];
	logic [KSEL_BITS-1:0]        cj [MAX_KERNEL];
	logic signed [ACC_BITS-1:0]  total;
	logic [Q_BITS-1:0]           q;
	logic [Q_BITS:0]             q_rnd;
	logic [COEF_FRAC_BITS-1:0]   rem;
	logic                        inc;

	// tap (i,j) takes the window element aligned to the bottom-right corner
	always_comb begin
		for (int i = 0; i < MAX_KERNEL; i++) begin
			ri[i] = KSEL_BITS'(MAX_KERNEL - int'(kr) + i);
			cj[i] = KSEL_BITS'(MAX_KERNEL - int'(kc) + i);
		end
		for (int i = 0; i < MAX_KERNEL; i++) begin
			for (int j = 0; j < MAX_KERNEL; j++) begin
				if (i < int'(kr) && j < int'(kc)) begin
					prod_c[i][j] = PROD_BITS'(coefs[i*MAX_KERNEL+j]) *
						PROD_BITS'($signed({1'b0, plane[ri[i]][cj[j]]}));
				end else begin
					prod_c[i][j] = '0;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_KERNEL; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < MAX_KERNEL; j++) begin
				row_c[i] = row_c[i] + ACC_BITS'(prod_s3[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c;
			row_s4  <= row_c;
		end
	end

	// round half to even, clamp to the pixel range
	always_comb begin
		total = '0;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			total = total + row_s4[i];
		end
		q     = total[ACC_BITS-1:COEF_FRAC_BITS];
		rem   = total[COEF_FRAC_BITS-1:0];
		inc   = (rem > (COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1))) ||
			((rem == (COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1))) && q[0]);
		q_rnd = {1'b0, q} + (Q_BITS + 1)'(inc);
		if (total[ACC_BITS-1] || total == '0) begin
			result = '0;
		end else if (q_rnd > (Q_BITS + 1)'((1 << PIXEL_BITS) - 1)) begin
			result = '1;
		end else begin
			result = q_rnd[PIXEL_BITS-1:0];
		end
	end

endmodule

@@ rtl/core/valid_region_2d_convolution.sv @@
// Valid-region 2D convolution over three-channel raster pixels.
// Input channel (in_valid/in_stall/in_data): each word is either a pixel in
// raster order or a coefficient write (signed Q3.12, index row*5+col).
// Every coefficient in use must be written before pixels reach it.
// Output channel (out_valid/out_stall/out_data): one word per window position
// fully inside the frame, with the per-channel filtered values, the anchor
// coordinate and a last-of-frame mark on the word caused by the final pixel.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while the block is idle.
// Throughput: one input word per cycle while in_stall is low. The stages from
// the accepting edge to the output register are line-buffer read, window
// shift, multiply, row sums, final sum and round.
// The pipeline advances as one; while the output register holds an untaken
// result and out_stall is high, in_stall is raised and every stage holds.
// Reset clears the counters, the stage valid bits and the configuration to
// 640x480 with a 3x3 kernel anchored at (1,1). Line and coefficient storage
// is not cleared and needs no clearing pass.
module valid_region_2d_convolution (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vrc_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output vrc_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import vrc_pkg::*;

	// configuration
	logic [CFG_W_BITS-1:0] width_q;
	logic [15:0]           height_q;
	logic [2:0]            krows_q, kcols_q, arow_q, acol_q;

	// frame position of the next pixel
	logic [COL_BITS-1:0]   col_q;
	logic [15:0]           row_q;

	logic                  en, acc, acc_pix;
	logic [CFG_W_BITS-1:0] w_eff, c_inc;
	logic [2:0]            kr_eff, kc_eff;
	logic [15:0]           last_row;
	logic [COL_BITS-1:0]   c_cur;
	logic                  wrap, emit_c, last_c;
	logic [15:0]           orow_c;
	logic [COL_BITS-1:0]   ocol_c;

	// stage 1: line-buffer read
	logic                  v_s1, cmd_s1, emit_s1, last_s1;
	rgb_t                  px_s1;
	logic [COL_BITS-1:0]   c_s1, ocol_s1;
	logic [15:0]           orow_s1;
	logic [4:0]            cidx_s1;
	coef_t                 cval_s1;
	// stage 2: window holds this word's neighborhood
	logic                  v_s2, cmd_s2, emit_s2, last_s2;
	logic [COL_BITS-1:0]   ocol_s2;
	logic [15:0]           orow_s2;
	logic [4:0]            cidx_s2;
	coef_t                 cval_s2;
	// stages 3 and 4: products and row sums inside the lanes
	logic                  v_s3, last_s3, v_s4, last_s4;
	logic [COL_BITS-1:0]   ocol_s3, ocol_s4;
	logic [15:0]           orow_s3, orow_s4;

	coef_arr_t             coef_q;
	win_ctl_t              wctl;
	window_t               window;
	plane_t                plane [CHANNELS];
	pix_t                  lane_res [CHANNELS];
	out_word_t             out_q;
	logic                  out_valid_q;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign acc       = in_valid && en;
	assign acc_pix   = acc && (in_data.command == CMD_PIXEL);
	assign cfg_ready = 1'b1;

	// clamp the sizes and derive where this pixel sits
	always_comb begin
		if (width_q == '0) begin
			w_eff = CFG_W_BITS'(1);
		end else if (width_q > CFG_W_BITS'(MAX_WIDTH)) begin
			w_eff = CFG_W_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		kr_eff   = (krows_q == '0) ? 3'd1 :
			(krows_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : krows_q;
		kc_eff   = (kcols_q == '0) ? 3'd1 :
			(kcols_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kcols_q;
		last_row = height_q - 16'd1;
		c_cur    = (CFG_W_BITS'(col_q) >= w_eff) ? '0 : col_q;
		c_inc    = CFG_W_BITS'(c_cur) + CFG_W_BITS'(1);
		wrap     = c_inc >= w_eff;
		emit_c   = ({1'b0, row_q} + 17'd1 >= 17'(kr_eff)) && (c_inc >= CFG_W_BITS'(kc_eff));
		last_c   = (row_q == last_row) && (c_inc == w_eff);
		orow_c   = row_q + 16'd1 - 16'(kr_eff) + 16'(arow_q);
		ocol_c   = COL_BITS'(c_inc - CFG_W_BITS'(kc_eff) + CFG_W_BITS'(acol_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W_BITS'(640);
			height_q <= 16'd480;
			krows_q  <= 3'd3;
			kcols_q  <= 3'd3;
			arow_q   <= 3'd1;
			acol_q   <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_KERNEL_ROWS:  krows_q  <= cfg_data[2:0];
				REG_KERNEL_COLS:  kcols_q  <= cfg_data[2:0];
				REG_ANCHOR_ROW:   arow_q   <= cfg_data[2:0];
				REG_ANCHOR_COL:   acol_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// advance the raster position on each pixel word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_pix) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= c_inc[COL_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= acc;
			v_s2        <= v_s1;
			// drop coefficient words and positions outside the valid region
			v_s3        <= v_s2 && (cmd_s2 == CMD_PIXEL) && emit_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= in_data.command;
			px_s1   <= {in_data.pixel_ch2, in_data.pixel_ch1, in_data.pixel_ch0};
			c_s1    <= c_cur;
			emit_s1 <= emit_c;
			last_s1 <= last_c;
			orow_s1 <= orow_c;
			ocol_s1 <= ocol_c;
			cidx_s1 <= in_data.coef_index;
			cval_s1 <= in_data.coef_value;

			cmd_s2  <= cmd_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			cidx_s2 <= cidx_s1;
			cval_s2 <= cval_s1;

			last_s3 <= last_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			last_s4 <= last_s3;
			orow_s4 <= orow_s3;
			ocol_s4 <= ocol_s3;

			// a coefficient lands at the multiply stage so older pixels keep the old one
			if (v_s2 && cmd_s2 == CMD_COEF && int'(cidx_s2) < NUM_COEF) begin
				coef_q[cidx_s2] <= cval_s2;
			end

			out_q.out_ch0    <= lane_res[0];
			out_q.out_ch1    <= lane_res[1];
			out_q.out_ch2    <= lane_res[2];
			out_q.out_row    <= orow_s4;
			out_q.out_col    <= ocol_s4;
			out_q.frame_last <= last_s4;
		end
	end

	always_comb begin
		wctl.rd_en   = acc_pix;
		wctl.wr_en   = en && v_s1 && (cmd_s1 == CMD_PIXEL);
		wctl.rd_addr = c_cur;
		wctl.wr_addr = c_s1;
	end

	vrc_window u_window (
		.clk    (clk),
		.ctl    (wctl),
		.px     (px_s1),
		.window (window)
	);

	// split the window into one plane per channel
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				for (int c = 0; c < MAX_KERNEL; c++) begin
					plane[ch][r][c] = window[c][r][ch];
				end
			end
		end
	end

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		vrc_lane u_lane (
			.clk    (clk),
			.en     (en),
			.plane  (plane[ch]),
			.coefs  (coef_q),
			.kr     (kr_eff),
			.kc     (kc_eff),
			.result (lane_res[ch])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_coef_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && cmd_s2 == CMD_COEF) |=> !v_s3)
		else $error("coefficient word produced a result");

	a_s4_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s4) |=> out_valid_q)
		else $error("result lost between row sums and output");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_pix && wrap) |=> (col_q == '0))
		else $error("column counter did not wrap at row end");

endmodule

@@ test/valid_region_2d_convolution_tb.sv @@
`timescale 1ns / 100ps

module valid_region_2d_convolution_tb;
	import vrc_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 8;    // margin for the block's pipeline to drain
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	valid_region_2d_convolution DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// free-running clock, 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Filter predictor: private copy of configuration, line history,
	// sliding window and coefficient store.
	// ------------------------------------------------------------------
	int unsigned img_w, img_h, k_rows, k_cols, anc_row, anc_col;
	int unsigned next_col, next_row;
	bit [7:0]    line_hist [MAX_KERNEL][MAX_WIDTH][CHANNELS];
	bit [7:0]    win_pix   [MAX_KERNEL][MAX_KERNEL][CHANNELS];
	int          coefs     [NUM_COEF];

	in_word_t  pending_q[$];   // words waiting to be driven
	out_word_t filtered_q[$];  // filtered words still to arrive
	int        fail_count;
	bit        calm;           // no idling on either side
	bit        want_hold;      // ask the receiver for one long hold-off

	function automatic int unsigned clamp_k(int unsigned k);
		if (k == 0) return 1;
		if (k > MAX_KERNEL) return MAX_KERNEL;
		return k;
	endfunction

	function automatic int unsigned eff_width();
		if (img_w == 0) return 1;
		if (img_w > MAX_WIDTH) return MAX_WIDTH;
		return img_w;
	endfunction

	// round half to even on the Q.12 sum, clip to 0..255
	function automatic bit [7:0] round_clip(longint acc);
		longint q, rem, half;
		if (acc <= 0) return 8'd0;
		q    = acc >>> COEF_FRAC_BITS;
		rem  = acc & ((longint'(1) << COEF_FRAC_BITS) - 1);
		half = longint'(1) << (COEF_FRAC_BITS - 1);
		if (rem > half || (rem == half && q[0])) q++;
		if (q > 255) q = 255;
		return q[7:0];
	endfunction

	function automatic void convolve(in_word_t w);
		int unsigned width, last_row, kr, kc, c, r;
		bit [7:0]    px [CHANNELS];
		longint      acc;
		out_word_t   res;
		bit [7:0]    chv [CHANNELS];
		if (w.command == CMD_COEF) begin
			if (w.coef_index < NUM_COEF) coefs[w.coef_index] = int'(w.coef_value);
			return;
		end
		width    = eff_width();
		last_row = (img_h - 1) & 16'hFFFF;
		kr       = clamp_k(k_rows);
		kc       = clamp_k(k_cols);
		if (next_col >= width) next_col = 0;
		c = next_col;
		r = next_row;
		px[0] = w.pixel_ch0;
		px[1] = w.pixel_ch1;
		px[2] = w.pixel_ch2;
		// shift this column's history up, append the new pixel
		for (int k = 0; k < MAX_KERNEL - 1; k++) line_hist[k][c] = line_hist[k+1][c];
		line_hist[MAX_KERNEL-1][c] = px;
		// shift the window left, load this column on the right
		for (int k = 0; k < MAX_KERNEL; k++) begin
			for (int m = 0; m < MAX_KERNEL - 1; m++) win_pix[k][m] = win_pix[k][m+1];
			win_pix[k][MAX_KERNEL-1] = line_hist[k][c];
		end
		if (r + 1 >= kr && c + 1 >= kc) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				acc = 0;
				for (int i = 0; i < kr; i++)
					for (int j = 0; j < kc; j++)
						acc += longint'(coefs[i*MAX_KERNEL + j]) *
							longint'(win_pix[MAX_KERNEL-kr+i][MAX_KERNEL-kc+j][ch]);
				chv[ch] = round_clip(acc);
			end
			res.out_ch0    = chv[0];
			res.out_ch1    = chv[1];
			res.out_ch2    = chv[2];
			res.out_row    = 16'(r + 1 - kr + anc_row);
			res.out_col    = 10'(c + 1 - kc + anc_col);
			res.frame_last = (r == last_row) && (c + 1 == width);
			filtered_q.push_back(res);
		end
		if (c + 1 >= width) begin
			next_col = 0;
			next_row = (r == last_row) ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			next_col = c + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer pending words, hold while stalled, idle in bursts.
	// ------------------------------------------------------------------
	int unsigned send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) convolve(in_data);
			if (in_valid && in_stall) begin
				// hold the stalled word
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(1, 13) - 1;
			end else if (pending_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random stall bursts, one long hold-off, compare each word.
	// ------------------------------------------------------------------
	int unsigned stall_left;
	bit          hold_done;

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, out_data);
					fail_count++;
				end else begin
					exp_w = filtered_q.pop_front();
					check_field("out_ch0", exp_w.out_ch0, out_data.out_ch0);
					check_field("out_ch1", exp_w.out_ch1, out_data.out_ch1);
					check_field("out_ch2", exp_w.out_ch2, out_data.out_ch2);
					check_field("out_row", exp_w.out_row, out_data.out_row);
					check_field("out_col", exp_w.out_col, out_data.out_col);
					check_field("frame_last", exp_w.frame_last, out_data.frame_last);
				end
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (want_hold && !hold_done) begin
				out_stall  <= 1'b1;
				stall_left <= HOLD_CYCLES - 1;
				hold_done  <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(1, 13) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	int unsigned cycle_count;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  img_w   = 32'(value & 16'h07FF);
			REG_IMAGE_HEIGHT: img_h   = 32'(value);
			REG_KERNEL_ROWS:  k_rows  = 32'(value & 16'h7);
			REG_KERNEL_COLS:  k_cols  = 32'(value & 16'h7);
			REG_ANCHOR_ROW:   anc_row = 32'(value & 16'h7);
			REG_ANCHOR_COL:   anc_col = 32'(value & 16'h7);
			default: ;
		endcase
	endtask

	task automatic set_shape(int unsigned w, int unsigned h, int unsigned kr,
			int unsigned kc, int unsigned ar, int unsigned ac);
		write_reg(REG_IMAGE_WIDTH, 16'(w));
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
		write_reg(REG_KERNEL_ROWS, 16'(kr));
		write_reg(REG_KERNEL_COLS, 16'(kc));
		write_reg(REG_ANCHOR_ROW, 16'(ar));
		write_reg(REG_ANCHOR_COL, 16'(ac));
	endtask

	// wait until every word went in and every result came out, sampling
	// between edges, then let the pipeline settle so a config write cannot
	// race a dropped word
	task automatic drain();
		@(negedge clk);
		while (pending_q.size() > 0 || in_valid || filtered_q.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_word_t pixel_word(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
		in_word_t    w;
		logic [63:0] junk;
		junk = {$urandom, $urandom};  // junk in the unused fields
		w = junk[$bits(in_word_t)-1:0];
		w.command   = CMD_PIXEL;
		w.pixel_ch0 = c0;
		w.pixel_ch1 = c1;
		w.pixel_ch2 = c2;
		return w;
	endfunction

	function automatic in_word_t coef_word(bit [4:0] idx, bit [15:0] value);
		in_word_t    w;
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		w = junk[$bits(in_word_t)-1:0];
		w.command    = CMD_COEF;
		w.coef_index = idx;
		w.coef_value = value;
		return w;
	endfunction

	function automatic in_word_t random_coef();
		bit [15:0] v;
		// mostly modest gains so the outputs land inside 0..255
		if ($urandom_range(0, 3) == 0) v = 16'($urandom);
		else v = 16'($signed($urandom_range(0, 3000)) - 1200);
		return coef_word(5'($urandom_range(0, 31)), v);
	endfunction

	// queue n_pix random pixels, with coefficient updates mixed in
	task automatic queue_frames(int unsigned n_pix);
		for (int unsigned i = 0; i < n_pix; i++) begin
			if ($urandom_range(0, 11) == 0) pending_q.push_back(random_coef());
			pending_q.push_back(pixel_word(8'($urandom), 8'($urandom), 8'($urandom)));
		end
	endtask

	function automatic int unsigned frame_pixels();
		return eff_width() * img_h;
	endfunction

	initial begin
		int unsigned half;
		bit [7:0]    tie_px [12];
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		calm       = 1'b0;
		want_hold  = 1'b0;
		img_w = 640; img_h = 480; k_rows = 3; k_cols = 3; anc_row = 1; anc_col = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fill every coefficient, extremes included, plus an index
		// past the store that must be dropped
		set_shape(4, 3, 1, 1, 0, 0);
		for (int i = 0; i < NUM_COEF; i++)
			pending_q.push_back(coef_word(5'(i), (i == 24) ? 16'h8000 :
				(i == 23) ? 16'h7FFF : 16'($urandom_range(0, 2000))));
		pending_q.push_back(coef_word(5'd31, 16'h1000));
		// a gain of one half puts every odd pixel on a tie
		pending_q.push_back(coef_word(5'd0, 16'h0800));
		tie_px = '{8'd0, 8'd1, 8'd3, 8'd5, 8'd255, 8'd254, 8'd7, 8'd128,
			8'd2, 8'd9, 8'd253, 8'd11};
		foreach (tie_px[i])
			pending_q.push_back(pixel_word(tie_px[i], ~tie_px[i], tie_px[(i+1) % 12]));
		drain();

		// negative gain clips to zero, full scale saturates
		pending_q.push_back(coef_word(5'd0, 16'h8000));
		queue_frames(frame_pixels());
		drain();
		pending_q.push_back(coef_word(5'd0, 16'h7FFF));
		queue_frames(frame_pixels());
		drain();

		// oversize width, zero height-of-kernel, oversize kernel width,
		// anchors past the kernel
		set_shape(2047, 1, 0, 6, 7, 7);
		queue_frames(frame_pixels());
		drain();

		// zero width means a single column
		set_shape(0, 6, 5, 1, 4, 0);
		queue_frames(frame_pixels());
		drain();

		// long receiver hold-off mid-frame, then a full sender pause
		set_shape(7, 9, 3, 3, 1, 1);
		half = frame_pixels() / 2;
		want_hold = 1'b1;
		queue_frames(half);
		drain();
		queue_frames(frame_pixels() - half);
		drain();

		set_shape(8, 6, 5, 5, 2, 3);
		queue_frames(frame_pixels());
		drain();

		// frame shorter than the kernel: no results at all
		set_shape(5, 4, 7, 0, 3, 4);
		queue_frames(frame_pixels());
		drain();

		set_shape($urandom_range(5, 8), $urandom_range(3, 6), $urandom_range(1, 5),
			$urandom_range(1, 5), $urandom_range(0, 7), $urandom_range(0, 7));
		queue_frames(frame_pixels());
		drain();

		// last part: no idling, height of zero wraps the last row to 65535
		calm = 1'b1;
		set_shape(9, 0, 3, 3, 1, 1);
		queue_frames(30);
		drain();

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/vrc_pkg.sv
rtl/core/vrc_window.sv
rtl/core/vrc_lane.sv
rtl/core/valid_region_2d_convolution.sv
test/valid_region_2d_convolution_tb.sv
